>>> hw/rtl/coo_to_csr_converter_macros.svh
// assertion macros for the sparse converter
`ifndef COO_TO_CSR_CONVERTER_MACROS_SVH
`define COO_TO_CSR_CONVERTER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define C2C_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// implication checked in the cycle after the antecedent holds
`define C2C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

>>> hw/rtl/c2c_pkg.sv
`timescale 1ns / 1ps
package c2c_pkg;
   localparam int unsigned MAX_VERTICES = 1024;
   localparam int unsigned MAX_EDGES    = 4096;
   localparam int unsigned VID_W        = 10;
   localparam int unsigned VAL_W        = 13;
   localparam int unsigned NV_W         = 11;
   localparam int unsigned OP_W         = 3;

   localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
   localparam logic [OP_W-1:0] OP_CONVERT = 3'd1;
   localparam logic [OP_W-1:0] OP_RD_ROW  = 3'd2;
   localparam logic [OP_W-1:0] OP_RD_COL  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_INDEX = 2'd3;

   localparam logic [0:0] CSR_NUM_VERTICES = 1'd0;
   localparam logic [0:0] CSR_INPUT_SORTED = 1'd1;
endpackage

>>> hw/rtl/coo_to_csr_converter.sv
`timescale 1ns / 1ps
// coo_to_csr_converter: coordinate edge list to compressed sparse row form
// Pulse start with opcode and fields while busy is low; the item is taken
// on that edge and busy rises. Exactly one result appears later on
// rsp_status/rsp_value for one cycle, marked by rsp_valid, and busy falls
// with it. The receiver cannot stall; nothing waits on it.
// Add edge, clear and reads pass through a memory read state and then a
// result state before the result register is loaded; no new item is taken
// until busy has fallen after the last one.
// Convert walks the stores in order: a zeroing pass, a check pass over the
// edges, a degree pass over the edges, a prefix pass over the vertices and
// a placement pass over the edges; unless input_sorted a row pass follows
// that insertion-sorts each row. Each memory used by the passes has a single port.
// After reset a clearing pass zeroes the row pointer and degree memories
// with busy held high; configuration writes are taken at any time while
// idle.
// csr_we/csr_index/csr_wdata write num_vertices (0) and input_sorted (1).
`include "coo_to_csr_converter_macros.svh"

module coo_to_csr_converter #(
   parameter int unsigned MAX_VERTICES = c2c_pkg::MAX_VERTICES,
   parameter int unsigned MAX_EDGES    = c2c_pkg::MAX_EDGES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [c2c_pkg::OP_W-1:0]    req_opcode,
   input  logic [c2c_pkg::VID_W-1:0]   req_source_vertex,
   input  logic [c2c_pkg::VID_W-1:0]   req_dest_vertex,
   input  logic [c2c_pkg::VAL_W-1:0]   req_read_index,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [c2c_pkg::VAL_W-1:0]   rsp_value,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [c2c_pkg::NV_W-1:0]    csr_wdata
);
   localparam int unsigned VA_W = $clog2(MAX_VERTICES + 1);  // row pointer address
   localparam int unsigned DA_W = $clog2(MAX_VERTICES);      // degree address
   localparam int unsigned EA_W = $clog2(MAX_EDGES);
   localparam int unsigned EC_W = $clog2(MAX_EDGES + 1);
   localparam int unsigned VC_W = $clog2(MAX_VERTICES + 1);
   localparam int unsigned VW   = c2c_pkg::VID_W;
   localparam int unsigned DW   = c2c_pkg::VAL_W;
   localparam int unsigned OP_W_C = c2c_pkg::OP_W;

   // state codes
   localparam logic [4:0] S_INIT   = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_RDWAIT = 5'd2;
   localparam logic [4:0] S_RESP   = 5'd3;
   localparam logic [4:0] S_ZERO   = 5'd4;
   localparam logic [4:0] S_CHK    = 5'd5;
   localparam logic [4:0] S_CHKW   = 5'd6;
   localparam logic [4:0] S_DEG    = 5'd7;
   localparam logic [4:0] S_DEGR   = 5'd8;
   localparam logic [4:0] S_DEGW   = 5'd9;
   localparam logic [4:0] S_PFX    = 5'd10;
   localparam logic [4:0] S_PFXW   = 5'd11;
   localparam logic [4:0] S_PLC    = 5'd12;
   localparam logic [4:0] S_PLCR   = 5'd13;
   localparam logic [4:0] S_PLCW   = 5'd14;
   localparam logic [4:0] S_ROW    = 5'd15;
   localparam logic [4:0] S_ROWW   = 5'd16;
   localparam logic [4:0] S_SORTI  = 5'd17;
   localparam logic [4:0] S_SKEY   = 5'd18;
   localparam logic [4:0] S_SCMP   = 5'd19;
   localparam logic [4:0] S_SCMPW  = 5'd20;
   localparam logic [4:0] S_SPUT   = 5'd21;
   localparam logic [4:0] S_FAIL   = 5'd22;

   // memories
   logic [VW-1:0] src_mem [MAX_EDGES];
   logic [VW-1:0] dst_mem [MAX_EDGES];
   logic [DW-1:0] deg_mem [MAX_VERTICES];
   logic [DW-1:0] rp_mem  [MAX_VERTICES+1];
   logic [VW-1:0] col_mem [MAX_EDGES];

   logic [4:0]      state_ff, state_in;
   logic [EC_W-1:0] loaded_ff, loaded_in;
   logic [EC_W-1:0] conv_ff, conv_in;
   logic [c2c_pkg::NV_W-1:0] nv_ff;
   logic            sorted_ff;
   logic [1:0]      st_ff, st_in;
   logic [DW-1:0]   val_ff, val_in;
   logic            rv_ff, rv_in;
   logic [OP_W_C-1:0] op_ff, op_in;
   logic [EC_W-1:0] e_ff, e_in;       // edge walk counter
   logic [VC_W-1:0] v_ff, v_in;       // vertex walk counter
   logic [DW-1:0]   sum_ff, sum_in;
   logic [EC_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [EC_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [VW-1:0]   key_ff, key_in;
   logic [DW-1:0]   idx_ff, idx_in;

   // memory port controls
   logic            e_we;  logic [EA_W-1:0] e_addr; logic [VW-1:0] src_wd, dst_wd;
   logic [VW-1:0]   src_rd, dst_rd;
   logic            d_we;  logic [VA_W-1:0] d_addr; logic [DW-1:0] d_wd, d_rd;
   logic            r_we;  logic [VA_W-1:0] r_addr; logic [DW-1:0] r_wd, r_rd;
   logic            c_we;  logic [EA_W-1:0] c_addr; logic [VW-1:0] c_wd, c_rd;

   // clamped vertex count
   logic [VC_W-1:0] nv_lim;
   always_comb begin
      if (nv_ff == '0) nv_lim = VC_W'(1);
      else if ({21'd0, nv_ff} > 32'(MAX_VERTICES)) nv_lim = VC_W'(MAX_VERTICES);
      else nv_lim = VC_W'(nv_ff);
   end

   // edge store
   always_ff @(posedge clock) begin
      if (e_we) begin
         src_mem[e_addr] <= src_wd;
         dst_mem[e_addr] <= dst_wd;
      end
      src_rd <= src_mem[e_addr];
      dst_rd <= dst_mem[e_addr];
   end

   // degree and cursor memory
   always_ff @(posedge clock) begin
      if (d_we) deg_mem[DA_W'(d_addr)] <= d_wd;
      d_rd <= deg_mem[DA_W'(d_addr)];
   end

   // row pointer memory
   always_ff @(posedge clock) begin
      if (r_we) rp_mem[r_addr] <= r_wd;
      r_rd <= rp_mem[r_addr];
   end

   // column memory
   always_ff @(posedge clock) begin
      if (c_we) col_mem[c_addr] <= c_wd;
      c_rd <= col_mem[c_addr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff     <= c2c_pkg::NV_W'(1024);
         sorted_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            c2c_pkg::CSR_NUM_VERTICES: nv_ff <= csr_wdata;
            default: sorted_ff <= csr_wdata[0];
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff; loaded_in = loaded_ff; conv_in = conv_ff;
      st_in = st_ff; val_in = val_ff; rv_in = 1'b0; op_in = op_ff;
      e_in = e_ff; v_in = v_ff; sum_in = sum_ff; lo_in = lo_ff; hi_in = hi_ff;
      i_in = i_ff; j_in = j_ff; key_in = key_ff; idx_in = idx_ff;
      e_we = 1'b0; e_addr = e_ff[EA_W-1:0];
      src_wd = req_source_vertex; dst_wd = req_dest_vertex;
      d_we = 1'b0; d_addr = v_ff; d_wd = '0;
      r_we = 1'b0; r_addr = v_ff; r_wd = '0;
      c_we = 1'b0; c_addr = j_ff[EA_W-1:0]; c_wd = key_ff;
      unique case (state_ff)
         // zero both vertex memories after reset
         S_INIT: begin
            r_we = 1'b1; d_we = (v_ff < VC_W'(MAX_VERTICES));
            if (v_ff == VC_W'(MAX_VERTICES)) state_in = S_IDLE;
            else v_in = v_ff + 1'b1;
         end
         S_IDLE: begin
            if (start) begin
               op_in = req_opcode; idx_in = req_read_index;
               st_in = c2c_pkg::ST_OK; val_in = '0;
               priority case (req_opcode)
                  c2c_pkg::OP_ADD: begin
                     if (loaded_ff == EC_W'(MAX_EDGES)) begin
                        st_in = c2c_pkg::ST_FULL; val_in = DW'(loaded_ff);
                     end else begin
                        e_we = 1'b1; e_addr = loaded_ff[EA_W-1:0];
                        loaded_in = loaded_ff + 1'b1; val_in = DW'(loaded_ff + 1'b1);
                     end
                     state_in = S_RDWAIT;
                  end
                  c2c_pkg::OP_CONVERT: begin
                     v_in = '0; state_in = S_ZERO; conv_in = '0;
                  end
                  c2c_pkg::OP_RD_ROW: begin
                     r_addr = VA_W'(req_read_index);
                     if ({19'd0, req_read_index} > 32'(nv_lim)) st_in = c2c_pkg::ST_INDEX;
                     state_in = S_RDWAIT;
                  end
                  c2c_pkg::OP_RD_COL: begin
                     c_addr = EA_W'(req_read_index);
                     if (32'(req_read_index) >= 32'(conv_ff)) st_in = c2c_pkg::ST_INDEX;
                     state_in = S_RDWAIT;
                  end
                  c2c_pkg::OP_CLEAR: begin
                     loaded_in = '0; state_in = S_RDWAIT;
                  end
                  default: state_in = S_RDWAIT;
               endcase
            end
         end
         // hold the read address so the read data stays for the result
         S_RDWAIT: begin
            r_addr = VA_W'(idx_ff); c_addr = EA_W'(idx_ff); state_in = S_RESP;
         end
         S_RESP: begin
            if (st_ff == c2c_pkg::ST_OK) begin
               if (op_ff == c2c_pkg::OP_RD_ROW) val_in = r_rd;
               else if (op_ff == c2c_pkg::OP_RD_COL) val_in = DW'(c_rd);
            end else if (st_ff == c2c_pkg::ST_INDEX) val_in = '0;
            rv_in = 1'b1; state_in = S_IDLE;
         end
         // clear row pointers and degrees
         S_ZERO: begin
            r_we = 1'b1; d_we = (v_ff < VC_W'(MAX_VERTICES));
            if (v_ff == VC_W'(MAX_VERTICES)) begin
               e_in = '0; state_in = S_CHK;
            end else v_in = v_ff + 1'b1;
         end
         // range check over the edge list
         S_CHK: begin
            if (e_ff == loaded_ff) begin
               e_in = '0; state_in = S_DEG;
            end else state_in = S_CHKW;
         end
         S_CHKW: begin
            if (VC_W'(src_rd) >= nv_lim) state_in = S_FAIL;
            else begin
               e_in = e_ff + 1'b1; e_addr = EA_W'(e_ff + 1'b1); state_in = S_CHK;
            end
         end
         S_FAIL: begin
            st_in = c2c_pkg::ST_RANGE; val_in = DW'(loaded_ff);
            rv_in = 1'b1; state_in = S_IDLE;
         end
         // degree count: read source, read degree, write back
         S_DEG: begin
            if (e_ff == loaded_ff) begin
               v_in = '0; sum_in = '0; state_in = S_PFX;
            end else state_in = S_DEGR;
         end
         S_DEGR: begin
            d_addr = VA_W'(src_rd); v_in = VC_W'(src_rd); state_in = S_DEGW;
         end
         S_DEGW: begin
            d_we = 1'b1; d_wd = d_rd + 1'b1;
            e_in = e_ff + 1'b1; e_addr = EA_W'(e_ff + 1'b1); state_in = S_DEG;
         end
         // prefix sum; degree memory becomes the fill cursor
         S_PFX: begin
            state_in = S_PFXW;
         end
         S_PFXW: begin
            r_we = 1'b1; r_wd = sum_ff;
            if (v_ff == nv_lim) begin
               e_in = '0; e_addr = '0; state_in = S_PLC;
            end else begin
               d_we = 1'b1; d_wd = sum_ff; sum_in = sum_ff + d_rd;
               v_in = v_ff + 1'b1; d_addr = v_ff; state_in = S_PFX;
            end
         end
         // place destinations by source
         S_PLC: begin
            if (e_ff == loaded_ff) begin
               if (sorted_ff) begin
                  conv_in = loaded_ff; st_in = c2c_pkg::ST_OK;
                  val_in = DW'(loaded_ff); rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  v_in = '0; state_in = S_ROW;
               end
            end else state_in = S_PLCR;
         end
         S_PLCR: begin
            d_addr = VA_W'(src_rd); v_in = VC_W'(src_rd); key_in = dst_rd;
            state_in = S_PLCW;
         end
         S_PLCW: begin
            d_we = 1'b1; d_wd = d_rd + 1'b1;
            c_we = 1'b1; c_addr = EA_W'(d_rd); c_wd = key_ff;
            e_in = e_ff + 1'b1; e_addr = EA_W'(e_ff + 1'b1); state_in = S_PLC;
         end
         // per-row insertion sort: fetch row bounds
         S_ROW: begin
            if (v_ff == nv_lim) begin
               conv_in = loaded_ff; st_in = c2c_pkg::ST_OK;
               val_in = DW'(loaded_ff); rv_in = 1'b1; state_in = S_IDLE;
            end else state_in = S_ROWW;
         end
         S_ROWW: begin
            // r_rd is row v start; fetch next
            lo_in = EC_W'(r_rd); r_addr = v_ff + 1'b1; state_in = S_SORTI;
            i_in = EC_W'(r_rd);
         end
         S_SORTI: begin
            hi_in = EC_W'(r_rd);
            if (i_ff + 1'b1 >= EC_W'(r_rd)) begin
               v_in = v_ff + 1'b1; r_addr = v_ff + 1'b1; state_in = S_ROW;
            end else begin
               i_in = i_ff + 1'b1; j_in = i_ff + 1'b1;
               c_addr = EA_W'(i_ff + 1'b1); state_in = S_SKEY;
            end
         end
         S_SKEY: begin
            key_in = c_rd; c_addr = EA_W'(j_ff - 1'b1); state_in = S_SCMP;
         end
         S_SCMP: begin
            c_addr = EA_W'(j_ff - 1'b1); state_in = S_SCMPW;
         end
         S_SCMPW: begin
            // c_rd holds entry j-1
            if (j_ff > lo_ff && c_rd > key_ff) begin
               c_we = 1'b1; c_addr = j_ff[EA_W-1:0]; c_wd = c_rd;
               j_in = j_ff - 1'b1; state_in = S_SPUT;
            end else begin
               c_we = 1'b1; c_addr = j_ff[EA_W-1:0]; c_wd = key_ff;
               r_addr = v_ff + 1'b1; state_in = S_SORTI;
            end
         end
         S_SPUT: begin
            if (j_ff > lo_ff) begin
               c_addr = EA_W'(j_ff - 1'b1); state_in = S_SCMP;
            end else begin
               c_we = 1'b1; c_addr = j_ff[EA_W-1:0]; c_wd = key_ff;
               r_addr = v_ff + 1'b1; state_in = S_SORTI;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_CHK && e_ff != loaded_ff) e_addr = e_ff[EA_W-1:0];
      if (state_ff == S_ROW) r_addr = v_ff;
      // a failed check leaves row pointers cleared and no converted edges
      if (state_ff == S_FAIL) conv_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; loaded_ff <= '0; conv_ff <= '0; rv_ff <= 1'b0;
         v_ff <= '0;
      end else begin
         state_ff <= state_in; loaded_ff <= loaded_in; conv_ff <= conv_in;
         rv_ff <= rv_in; v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in; val_ff <= val_in; op_ff <= op_in; e_ff <= e_in;
      sum_ff <= sum_in; lo_ff <= lo_in; hi_ff <= hi_in; i_ff <= i_in;
      j_ff <= j_in; key_ff <= key_in; idx_ff <= idx_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_value  = val_ff;

   // checks
   `C2C_ASSERT_IMP(a_load_bound, clock, reset, 1'b1, loaded_ff <= EC_W'(MAX_EDGES))
   `C2C_ASSERT_NEXT(a_take_busy, clock, reset, start && !busy, busy)
   `C2C_ASSERT_NEXT(a_rsp_idle, clock, reset, rsp_valid, !rsp_valid)
endmodule
